FILE: rtl/fpt_pkg.sv
// Shared types and constants for the frame pacing timer.
// Used by fpt_div_serial and frame_pacing_timer; depends on nothing.
package fpt_pkg;

	// configuration port
	localparam int CFG_W     = 18;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLED      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED        = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SINGLE_CALL  = 2'd3;

	localparam logic [9:0]  SPEED_RESET        = 10'd60;
	localparam logic [17:0] MIN_INTERVAL_RESET = 18'd64;

	// opcodes
	localparam logic [1:0] OP_SAMPLE   = 2'd0;
	localparam logic [1:0] OP_PROCESS  = 2'd1;
	localparam logic [1:0] OP_REANCHOR = 2'd2;

	// arithmetic
	localparam int QUO_BITS      = 24;    // quotient bits per serial division
	localparam int ACC_FRAC_BITS = 16;    // tick accumulator fraction bits
	localparam int ACCUM_W       = 20;
	localparam int TICK_W        = 4;
	localparam int MS_PER_S      = 1000;
	localparam int TICK_SPAN_MS  = 8000;  // elapsed time that hits the cap at any nonzero speed

	localparam logic [15:0]        RATE_MAX  = 16'hFFFF;
	localparam logic [23:0]        LAT_MAX   = 24'hFFFFFF;
	localparam logic [ACCUM_W-1:0] ACCUM_MAX = 20'hFFFFF;
	localparam logic [ACCUM_W-1:0] DELTA_CAP = 20'h80000;
	localparam logic [9:0]         WAIT_MAX  = 10'd1000;
	localparam logic [9:0]         IDLE_WAIT = 10'd5;
	localparam logic [TICK_W-1:0]  ONE_TICK  = 4'd1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EVAL,
		ST_RATE,
		ST_RATE_WAIT,
		ST_LAT,
		ST_LAT_WAIT,
		ST_TICK,
		ST_TICK_WAIT,
		ST_CHECK,
		ST_DONE
	} fpt_state_t;

	typedef enum logic [1:0] {
		DV_IDLE,
		DV_CHECK,
		DV_RUN,
		DV_ROUND
	} div_state_t;

	typedef struct packed {
		logic                done;
		logic                ovf;       // quotient does not fit QUO_BITS
		logic                round_up;  // remainder at least half the divisor
		logic [QUO_BITS-1:0] quo;
	} div_res_t;

endpackage

FILE: rtl/fpt_div_serial.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on fpt_pkg (QUO_BITS, div_state_t, div_res_t).
module fpt_div_serial #(
	parameter int DIV_W = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_W-1:0]  num,
	input  logic [DIV_W-1:0]  den,
	output fpt_pkg::div_res_t res
);
	import fpt_pkg::*;

	localparam int CNT_W = $clog2(QUO_BITS);

	div_state_t state_q, state_d;

	logic [DIV_W-1:0]    rem_q, den_q;
	logic [QUO_BITS-1:0] digit_q;   // low numerator bits in, quotient bits out
	logic [CNT_W-1:0]    cnt_q;
	logic                ovf_q, round_q, done_q;
	logic [DIV_W:0]      trial, diff;
	logic                take;

	always_comb begin
		trial = {rem_q, digit_q[QUO_BITS-1]};
		diff  = trial - {1'b0, den_q};
		take  = trial >= {1'b0, den_q};
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			DV_IDLE: begin
				if (start)
					state_d = DV_CHECK;
			end
			DV_CHECK: state_d = DV_RUN;
			DV_RUN: begin
				if (cnt_q == '0)
					state_d = DV_ROUND;
			end
			DV_ROUND: state_d = DV_IDLE;
			default: state_d = DV_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == DV_ROUND);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			DV_IDLE: begin
				if (start) begin
					rem_q   <= num >> QUO_BITS;
					digit_q <= num[QUO_BITS-1:0];
					den_q   <= den;
				end
			end
			DV_CHECK: begin
				ovf_q <= rem_q >= den_q;
				cnt_q <= CNT_W'(QUO_BITS - 1);
			end
			DV_RUN: begin
				rem_q   <= take ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
				digit_q <= {digit_q[QUO_BITS-2:0], take};
				cnt_q   <= cnt_q - 1'b1;
			end
			DV_ROUND: begin
				round_q <= {rem_q, 1'b0} >= {1'b0, den_q};
			end
			default: ;
		endcase
	end

	assign res = '{done: done_q, ovf: ovf_q, round_up: round_q, quo: digit_q};

endmodule

FILE: rtl/frame_pacing_timer.sv
// Frame pacing timer, top level; depends on fpt_pkg and fpt_div_serial.
// Times are ms in fixed point with TIME_FRAC_BITS fraction bits. A sample word (opcode 0)
// counts a frame, measures the rounded frame rate once a second has gone by, measures the
// mean frame latency once more than 1 ms has gone by, adds the scaled elapsed time (capped
// at 8 ticks) to a Q16 tick accumulator once per process word, and works out the wait before
// the next sample from recheck_time. A process word (opcode 1) hands out the whole ticks, or
// one tick in single-call mode. Opcode 2 re-anchors and clears the accumulator. Time running
// backwards re-anchors and flags was_reset; a disabled timer re-anchors and asks for 5 ms.
// Every input word gives exactly one result word. Process, re-anchor and disabled words skip
// the divider. An enabled sample word runs its rate, latency and tick divisions, each only
// when needed, one after another through one shared bit-serial divider that makes one of
// its 24 quotient bits per cycle. The last step also waits for as long as the previous
// result is still stalled in the output register. The next input word is taken once the
// result sits in the output register, even if it is still stalled there.
module frame_pacing_timer #(
	parameter int TIME_WIDTH     = 48,
	parameter int COUNT_WIDTH    = 16,
	parameter int TIME_FRAC_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration writes
	input  logic                          cfg_we,
	input  logic [fpt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fpt_pkg::CFG_W-1:0]     cfg_data,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    opcode,
	input  logic [TIME_WIDTH-1:0]         sample_time,
	input  logic [TIME_WIDTH-1:0]         recheck_time,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [15:0]                   frame_rate,
	output logic [23:0]                   latency,
	output logic [3:0]                    tick_count,
	output logic [9:0]                    wait_ms,
	output logic                          was_reset
);
	import fpt_pkg::*;

	// widths of the divider operands
	localparam int LIM_W      = 13 + TIME_FRAC_BITS;       // holds 8000 ms
	localparam int RATE_MUL_W = COUNT_WIDTH + 10;          // 1000 * frames
	localparam int RATE_NUM_W = RATE_MUL_W + TIME_FRAC_BITS;
	localparam int TICK_MUL_W = LIM_W + 10;                // elapsed * speed
	localparam int TICK_NUM_W = TICK_MUL_W + ACC_FRAC_BITS - TIME_FRAC_BITS;
	localparam int DIV_W0     = (RATE_NUM_W > TIME_WIDTH) ? RATE_NUM_W : TIME_WIDTH;
	localparam int DIV_W      = (TICK_NUM_W > DIV_W0) ? TICK_NUM_W : DIV_W0;
	localparam int SUM_W      = QUO_BITS + 1;

	localparam logic [TIME_WIDTH-1:0] ONE_MS    = TIME_WIDTH'(1) << TIME_FRAC_BITS;
	localparam logic [TIME_WIDTH-1:0] SLOW_SPAN = TIME_WIDTH'(MS_PER_S) << TIME_FRAC_BITS;
	localparam logic [TIME_WIDTH-1:0] TICK_LIM  = TIME_WIDTH'(TICK_SPAN_MS) << TIME_FRAC_BITS;
	localparam logic [CFG_W-1:0]      WAIT_CHECK = CFG_W'(2) << TIME_FRAC_BITS;
	localparam logic [CFG_W:0]        HALF_MS    = (CFG_W + 1)'(1) << (TIME_FRAC_BITS - 1);

	// configuration
	logic              enabled_q, single_q;
	logic [9:0]        speed_q;
	logic [CFG_W-1:0]  min_interval_q;

	// timer state
	logic [TIME_WIDTH-1:0]  qa_q, sa_q;       // quick and slow anchors
	logic [COUNT_WIDTH-1:0] qf_q, sf_q;       // quick and slow frame counts
	logic [15:0]            rate_q;
	logic [23:0]            lat_q;
	logic [ACCUM_W-1:0]     accum_q;
	logic                   processed_q;

	// per-word working registers
	logic [1:0]            op_q;
	logic [TIME_WIDTH-1:0] now_q, again_q, qd_q, sd_q;
	logic [TICK_W-1:0]     tick_q;
	logic [9:0]            wait_q;
	logic                  back_q;

	// result register
	logic        out_valid_q, was_reset_q;
	logic [15:0] frame_rate_q;
	logic [23:0] latency_q;
	logic [3:0]  tick_count_q;
	logic [9:0]  wait_ms_q;

	fpt_state_t state_q, state_d;

	// divider hookup
	logic             div_start;
	logic [DIV_W-1:0] div_num, div_den;
	div_res_t         res;

	// datapath helpers
	logic                   now_back, again_back, slow_hit, quick_hit, wait_on;
	logic                   tick_direct, out_load;
	logic [COUNT_WIDTH-1:0] qf_inc, sf_inc;
	logic [RATE_MUL_W-1:0]  rate_prod;
	logic [TICK_MUL_W-1:0]  tick_prod;
	logic [SUM_W-1:0]       rnd_sum;
	logic [15:0]            rate_new;
	logic [23:0]            lat_new;
	logic [ACCUM_W-1:0]     delta_div, delta_imm, delta_sel, accum_new;
	logic [ACCUM_W:0]       accum_sum;
	logic [TIME_WIDTH-1:0]  qd2;
	logic                   need_wait;
	logic [CFG_W-1:0]       wdiff;
	logic [CFG_W:0]         w_sum, w_ms;
	logic [9:0]             wait_new;

	fpt_div_serial #(
		.DIV_W (DIV_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.res    (res)
	);

	always_comb begin
		now_back   = (now_q < qa_q) || (now_q < sa_q);
		again_back = (again_q < qa_q) || (again_q < sa_q);
		slow_hit   = sd_q >= SLOW_SPAN;
		quick_hit  = qd_q > ONE_MS;
		wait_on    = min_interval_q > WAIT_CHECK;
		qf_inc     = (qf_q == '1) ? qf_q : qf_q + 1'b1;
		sf_inc     = (sf_q == '1) ? sf_q : sf_q + 1'b1;

		// no division for the tick delta when speed is zero or elapsed time has reached the cap span
		tick_direct = (speed_q == '0) || (qd_q >= TICK_LIM);
		delta_imm   = (speed_q == '0) ? '0 : DELTA_CAP;

		rate_prod = RATE_MUL_W'(sf_q) * RATE_MUL_W'(MS_PER_S);
		tick_prod = TICK_MUL_W'(qd_q[LIM_W-1:0]) * TICK_MUL_W'(speed_q);

		// rounded and saturated division results
		rnd_sum  = SUM_W'(res.quo) + SUM_W'(res.round_up);
		rate_new = (res.ovf || rnd_sum > SUM_W'(RATE_MAX)) ? RATE_MAX : rnd_sum[15:0];
		lat_new  = (res.ovf || rnd_sum > SUM_W'(LAT_MAX)) ? LAT_MAX : rnd_sum[23:0];
		delta_div = (res.ovf || res.quo > QUO_BITS'(DELTA_CAP)) ? DELTA_CAP
			: res.quo[ACCUM_W-1:0];
		delta_sel = (state_q == ST_TICK_WAIT) ? delta_div : delta_imm;
		accum_sum = {1'b0, accum_q} + {1'b0, delta_sel};
		accum_new = accum_sum[ACCUM_W] ? ACCUM_MAX : accum_sum[ACCUM_W-1:0];

		// wait from the second reading, against the quick anchor as it stands now
		qd2       = again_q - qa_q;
		need_wait = qd2 < TIME_WIDTH'(min_interval_q);
		wdiff     = min_interval_q - qd2[CFG_W-1:0];
		w_sum     = {1'b0, wdiff} + HALF_MS;
		w_ms      = w_sum >> TIME_FRAC_BITS;
		wait_new  = (w_ms > (CFG_W + 1)'(WAIT_MAX)) ? WAIT_MAX : w_ms[9:0];
	end

	// divider operands by step
	always_comb begin
		case (state_q)
			ST_RATE: begin
				div_num = DIV_W'(rate_prod) << TIME_FRAC_BITS;
				div_den = DIV_W'(sd_q);
			end
			ST_LAT: begin
				div_num = DIV_W'(qd_q);
				div_den = DIV_W'(qf_q);
			end
			default: begin
				div_num = DIV_W'(tick_prod) << (ACC_FRAC_BITS - TIME_FRAC_BITS);
				div_den = DIV_W'(MS_PER_S);
			end
		endcase
	end

	// sequencer
	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid)
					state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (op_q == OP_SAMPLE && enabled_q && !now_back)
					state_d = ST_RATE;
				else
					state_d = ST_DONE;
			end
			ST_RATE: begin
				if (slow_hit) begin
					div_start = 1'b1;
					state_d   = ST_RATE_WAIT;
				end else begin
					state_d = ST_LAT;
				end
			end
			ST_RATE_WAIT: begin
				if (res.done)
					state_d = ST_LAT;
			end
			ST_LAT: begin
				if (!quick_hit) begin
					state_d = ST_CHECK;
				end else if (qf_q == '0) begin
					state_d = ST_TICK;
				end else begin
					div_start = 1'b1;
					state_d   = ST_LAT_WAIT;
				end
			end
			ST_LAT_WAIT: begin
				if (res.done)
					state_d = ST_TICK;
			end
			ST_TICK: begin
				if (processed_q && !tick_direct) begin
					div_start = 1'b1;
					state_d   = ST_TICK_WAIT;
				end else begin
					state_d = ST_CHECK;
				end
			end
			ST_TICK_WAIT: begin
				if (res.done)
					state_d = ST_CHECK;
			end
			ST_CHECK: state_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q      <= 1'b0;
			speed_q        <= SPEED_RESET;
			min_interval_q <= MIN_INTERVAL_RESET;
			single_q       <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENABLED:      enabled_q      <= cfg_data[0];
				REG_SPEED:        speed_q        <= cfg_data[9:0];
				REG_MIN_INTERVAL: min_interval_q <= cfg_data;
				REG_SINGLE_CALL:  single_q       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// timer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qa_q        <= '0;
			sa_q        <= '0;
			qf_q        <= '0;
			sf_q        <= '0;
			rate_q      <= '0;
			lat_q       <= '0;
			accum_q     <= '0;
			processed_q <= 1'b0;
		end else begin
			case (state_q)
				ST_EVAL: begin
					case (op_q)
						OP_SAMPLE: begin
							if (!enabled_q || now_back) begin
								qa_q <= now_q;
								sa_q <= now_q;
								qf_q <= '0;
								sf_q <= '0;
								if (enabled_q)
									accum_q <= '0;
							end else begin
								qf_q <= qf_inc;
								sf_q <= sf_inc;
							end
						end
						OP_PROCESS: begin
							processed_q <= 1'b1;
							if (accum_q[ACCUM_W-1:ACC_FRAC_BITS] != '0) begin
								if (single_q)
									accum_q <= '0;
								else
									accum_q <= {{(ACCUM_W - ACC_FRAC_BITS){1'b0}},
										accum_q[ACC_FRAC_BITS-1:0]};
							end
						end
						OP_REANCHOR: begin
							qa_q    <= now_q;
							sa_q    <= now_q;
							qf_q    <= '0;
							sf_q    <= '0;
							accum_q <= '0;
						end
						default: ;
					endcase
				end
				ST_RATE_WAIT: begin
					if (res.done) begin
						rate_q <= rate_new;
						sa_q   <= now_q;
						sf_q   <= '0;
					end
				end
				ST_LAT: begin
					if (quick_hit && qf_q == '0)
						lat_q <= '0;
				end
				ST_LAT_WAIT: begin
					if (res.done)
						lat_q <= lat_new;
				end
				ST_TICK: begin
					// tick operands come from qd_q, not the anchor, so the quick anchor moves now
					qa_q <= now_q;
					qf_q <= '0;
					if (processed_q && tick_direct) begin
						accum_q     <= accum_new;
						processed_q <= 1'b0;
					end
				end
				ST_TICK_WAIT: begin
					if (res.done) begin
						accum_q     <= accum_new;
						processed_q <= 1'b0;
					end
				end
				ST_CHECK: begin
					if (wait_on && again_back) begin
						qa_q    <= again_q;
						sa_q    <= again_q;
						qf_q    <= '0;
						sf_q    <= '0;
						accum_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// per-word working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					op_q    <= opcode;
					now_q   <= sample_time;
					again_q <= recheck_time;
				end
			end
			ST_EVAL: begin
				qd_q <= now_q - qa_q;
				sd_q <= now_q - sa_q;
				// ticks go out only on a process word that finds a whole one
				if (op_q == OP_PROCESS && accum_q[ACCUM_W-1:ACC_FRAC_BITS] != '0)
					tick_q <= single_q ? ONE_TICK : accum_q[ACCUM_W-1:ACC_FRAC_BITS];
				else
					tick_q <= '0;
				wait_q <= (op_q == OP_SAMPLE && !enabled_q) ? IDLE_WAIT : '0;
				back_q <= (op_q == OP_SAMPLE) && enabled_q && now_back;
			end
			ST_CHECK: begin
				if (wait_on) begin
					if (again_back)
						back_q <= 1'b1;
					else if (need_wait)
						wait_q <= wait_new;
				end
			end
			default: ;
		endcase
	end

	// result register: frees the sequencer while the word waits downstream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			frame_rate_q <= rate_q;
			latency_q    <= lat_q;
			tick_count_q <= tick_q;
			wait_ms_q    <= wait_q;
			was_reset_q  <= back_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_rate = frame_rate_q;
	assign latency    = latency_q;
	assign tick_count = tick_count_q;
	assign wait_ms    = wait_ms_q;
	assign was_reset  = was_reset_q;

endmodule

FILE: dv/fpt_result_checker.sv
`timescale 1ns / 1ps
// Result checker for frame_pacing_timer: follows the config port and both word channels,
// predicts each result word and compares it field by field. Depends on fpt_pkg.
module fpt_result_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [fpt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fpt_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [1:0]                    opcode,
	input  logic [47:0]                   sample_time,
	input  logic [47:0]                   recheck_time,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [15:0]                   frame_rate,
	input  logic [23:0]                   latency,
	input  logic [3:0]                    tick_count,
	input  logic [9:0]                    wait_ms,
	input  logic                          was_reset,
	output int                            mismatches,
	output int                            outstanding
);
	import fpt_pkg::*;

	localparam logic [63:0] ONE_MS     = 64'd256;
	localparam logic [63:0] SECOND     = 64'd1000 * ONE_MS;
	localparam logic [63:0] TICK_SPAN  = 64'd8000 * ONE_MS;
	localparam logic [63:0] WAIT_CHECK = 64'd2 * ONE_MS;

	typedef struct packed {
		logic [15:0] frame_rate;
		logic [23:0] latency;
		logic [3:0]  tick_count;
		logic [9:0]  wait_ms;
		logic        was_reset;
	} timer_word_t;

	// configuration copy
	logic        run_enabled;
	logic [9:0]  tick_speed;
	logic [17:0] frame_gap;
	logic        one_shot;

	// timer state copy
	logic [47:0]        quick_anchor, slow_anchor;
	logic [15:0]        quick_frames, slow_frames;
	logic [15:0]        rate_hold;
	logic [23:0]        latency_hold;
	logic [ACCUM_W-1:0] tick_accum;
	logic               processed_flag;

	timer_word_t due_words[$];
	timer_word_t want;

	function automatic logic [63:0] div_half_up(logic [63:0] num, logic [63:0] den);
		logic [63:0] q, r;
		q = num / den;
		r = num % den;
		if (r >= den - r)
			q = q + 64'd1;
		return q;
	endfunction

	// Q16 ticks earned over span, capped at 8
	function automatic logic [63:0] ticks_earned(logic [63:0] span);
		logic [63:0] d;
		if (tick_speed == 10'd0)
			return 64'd0;
		if (span >= TICK_SPAN)
			return 64'(DELTA_CAP);
		d = ((span * tick_speed) << ACC_FRAC_BITS) / SECOND;
		return (d > 64'(DELTA_CAP)) ? 64'(DELTA_CAP) : d;
	endfunction

	function automatic void set_anchors(logic [47:0] t);
		quick_anchor = t;
		slow_anchor  = t;
		quick_frames = '0;
		slow_frames  = '0;
	endfunction

	function automatic timer_word_t advance_timer(logic [1:0] op, logic [47:0] t_now,
			logic [47:0] t_again);
		timer_word_t w;
		logic [63:0] now, again, qd, sd, v;
		w     = '0;
		now   = 64'(t_now);
		again = 64'(t_again);
		case (op)
		OP_SAMPLE: begin
			if (!run_enabled) begin
				set_anchors(t_now);
				w.wait_ms = IDLE_WAIT;
			end else if (now < quick_anchor || now < slow_anchor) begin
				tick_accum = '0;
				set_anchors(t_now);
				w.was_reset = 1'b1;
			end else begin
				if (quick_frames != 16'hFFFF)
					quick_frames = quick_frames + 16'd1;
				if (slow_frames != 16'hFFFF)
					slow_frames = slow_frames + 16'd1;
				qd = now - quick_anchor;
				sd = now - slow_anchor;
				if (sd >= SECOND) begin
					v = div_half_up((64'd1000 * slow_frames) << 8, sd);
					rate_hold   = (v > 64'(RATE_MAX)) ? RATE_MAX : v[15:0];
					slow_anchor = t_now;
					slow_frames = '0;
				end
				if (qd > ONE_MS) begin
					v = div_half_up(qd, 64'(quick_frames));
					latency_hold = (v > 64'(LAT_MAX)) ? LAT_MAX : v[23:0];
					if (processed_flag) begin
						v = 64'(tick_accum) + ticks_earned(qd);
						tick_accum = (v > 64'(ACCUM_MAX)) ? ACCUM_MAX : v[ACCUM_W-1:0];
						processed_flag = 1'b0;
					end
					quick_anchor = t_now;
					quick_frames = '0;
				end
				if (64'(frame_gap) > WAIT_CHECK) begin
					if (again < quick_anchor || again < slow_anchor) begin
						tick_accum = '0;
						set_anchors(t_again);
						w.was_reset = 1'b1;
					end else begin
						qd = again - quick_anchor;
						if (qd < 64'(frame_gap)) begin
							v = ((64'(frame_gap) - qd) + (ONE_MS >> 1)) >> 8;
							w.wait_ms = (v > 64'(WAIT_MAX)) ? WAIT_MAX : v[9:0];
						end
					end
				end
			end
		end
		OP_PROCESS: begin
			processed_flag = 1'b1;
			if (tick_accum[ACCUM_W-1:ACC_FRAC_BITS] != '0) begin
				if (one_shot) begin
					tick_accum   = '0;
					w.tick_count = ONE_TICK;
				end else begin
					w.tick_count = tick_accum[ACCUM_W-1:ACC_FRAC_BITS];
					tick_accum   = {{(ACCUM_W-ACC_FRAC_BITS){1'b0}},
						tick_accum[ACC_FRAC_BITS-1:0]};
				end
			end
		end
		OP_REANCHOR: begin
			tick_accum = '0;
			set_anchors(t_now);
		end
		default: ;
		endcase
		w.frame_rate = rate_hold;
		w.latency    = latency_hold;
		return w;
	endfunction

	task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
		mismatches = mismatches + 1;
		$display("%0t: mismatch %s: got %0d, expected %0d", $realtime, what, got, exp_val);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_enabled    = 1'b0;
			tick_speed     = SPEED_RESET;
			frame_gap      = MIN_INTERVAL_RESET;
			one_shot       = 1'b0;
			quick_anchor   = '0;
			slow_anchor    = '0;
			quick_frames   = '0;
			slow_frames    = '0;
			rate_hold      = '0;
			latency_hold   = '0;
			tick_accum     = '0;
			processed_flag = 1'b0;
			due_words.delete();
			mismatches     = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (due_words.size() == 0) begin
					flag_mismatch("result word with none due, frame_rate", 64'(frame_rate), 0);
				end else begin
					want = due_words.pop_front();
					if (frame_rate !== want.frame_rate)
						flag_mismatch("frame_rate", 64'(frame_rate), 64'(want.frame_rate));
					if (latency !== want.latency)
						flag_mismatch("latency", 64'(latency), 64'(want.latency));
					if (tick_count !== want.tick_count)
						flag_mismatch("tick_count", 64'(tick_count), 64'(want.tick_count));
					if (wait_ms !== want.wait_ms)
						flag_mismatch("wait_ms", 64'(wait_ms), 64'(want.wait_ms));
					if (was_reset !== want.was_reset)
						flag_mismatch("was_reset", 64'(was_reset), 64'(want.was_reset));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
				REG_ENABLED:      run_enabled = cfg_data[0];
				REG_SPEED:        tick_speed  = cfg_data[9:0];
				REG_MIN_INTERVAL: frame_gap   = cfg_data[17:0];
				REG_SINGLE_CALL:  one_shot    = cfg_data[0];
				default: ;
				endcase
			end
			if (in_valid && !in_stall)
				due_words.push_back(advance_timer(opcode, sample_time, recheck_time));
		end
		outstanding = due_words.size();
	end

endmodule

FILE: dv/frame_pacing_timer_tb.sv
`timescale 1ns / 1ps
// Testbench top for frame_pacing_timer: clock, reset, config phases and word stimulus.
// Depends on fpt_pkg, the RTL and fpt_result_checker, which predicts and compares results.
module frame_pacing_timer_tb;
	import fpt_pkg::*;

	// opcode 3 is unassigned: the block must answer it without touching state
	localparam logic [1:0] OP_UNDEFINED = 2'd3;
	localparam int PHASES      = 7;
	localparam int PHASE_WORDS = 220;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index    = '0;
	logic [CFG_W-1:0]     cfg_data     = '0;
	logic                 in_valid     = 1'b0;
	logic                 in_stall;
	logic [1:0]           opcode       = OP_SAMPLE;
	logic [47:0]          sample_time  = '0;
	logic [47:0]          recheck_time = '0;
	logic                 out_valid;
	logic                 out_stall    = 1'b0;
	logic [15:0]          frame_rate;
	logic [23:0]          latency;
	logic [3:0]           tick_count;
	logic [9:0]           wait_ms;
	logic                 was_reset;
	int                   mismatches;
	int                   outstanding;

	// both sides idle at random while this is set; cleared for one long calm phase
	logic                 idling = 1'b1;
	// free-running notion of "now" for the sample words, Q8 ms
	logic [47:0]          clock_now = '0;

	always #5 clk = ~clk;

	frame_pacing_timer i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.sample_time  (sample_time),
		.recheck_time (recheck_time),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.frame_rate   (frame_rate),
		.latency      (latency),
		.tick_count   (tick_count),
		.wait_ms      (wait_ms),
		.was_reset    (was_reset)
	);

	fpt_result_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.sample_time  (sample_time),
		.recheck_time (recheck_time),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.frame_rate   (frame_rate),
		.latency      (latency),
		.tick_count   (tick_count),
		.wait_ms      (wait_ms),
		.was_reset    (was_reset),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	// Result side backpressure: independent of out_valid, so stalls land on
	// every phase of the block's work, including while the result sits waiting.
	always @(posedge clk)
		out_stall <= idling && ($urandom_range(0, 99) < 24);

	function automatic logic [47:0] any_time();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[47:0];
	endfunction

	// Present one word and hold it until taken. Stall is looked at on the falling
	// edge, where everything driven at the rising edge has settled.
	task automatic send_word(logic [1:0] op, logic [47:0] t_sample, logic [47:0] t_recheck);
		while (idling && $urandom_range(0, 99) < 24) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		opcode       <= op;
		sample_time  <= t_sample;
		recheck_time <= t_recheck;
		do @(negedge clk); while (in_stall);
		@(posedge clk);
	endtask

	// Drop valid and wait for every predicted result to come back. Each word gives
	// exactly one result, so an empty expectation list means the block is idle.
	task automatic settle();
		in_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	// cfg_we stays high across back-to-back writes; the caller lowers it
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	task automatic configure(logic en, logic [9:0] speed, logic [17:0] gap, logic one_shot);
		write_reg(REG_ENABLED, CFG_W'(en));
		write_reg(REG_SPEED, CFG_W'(speed));
		write_reg(REG_MIN_INTERVAL, CFG_W'(gap));
		write_reg(REG_SINGLE_CALL, CFG_W'(one_shot));
		cfg_we <= 1'b0;
	endtask

	// Mostly a plausible frame loop: time creeps forward by up to 16 ms, now and
	// then jumps a second or more so the rate gets measured, and sometimes runs
	// backwards or lands anywhere. Process words are interleaved so the tick
	// accumulator gets fed; re-anchors and undefined opcodes are the noise.
	task automatic random_word();
		int pick, step;
		logic [47:0] t_recheck;
		pick = $urandom_range(0, 99);
		step = $urandom_range(0, 99);
		if (step < 6)
			clock_now = clock_now + 48'($urandom_range(256000, 600000));
		else if (step < 8)
			clock_now = clock_now - 48'($urandom_range(1, 4096));
		else if (step < 10)
			clock_now = any_time();
		else
			clock_now = clock_now + 48'($urandom_range(0, 4096));
		step = $urandom_range(0, 99);
		if (step < 80)
			t_recheck = clock_now + 48'($urandom_range(0, 3000));
		else if (step < 92)
			t_recheck = clock_now + 48'($urandom_range(0, 300000));
		else
			t_recheck = clock_now - 48'($urandom_range(1, 2000));
		if (pick < 60)
			send_word(OP_SAMPLE, clock_now, t_recheck);
		else if (pick < 85)
			send_word(OP_PROCESS, any_time(), any_time());
		else if (pick < 93)
			send_word(OP_REANCHOR, clock_now, any_time());
		else
			send_word(OP_UNDEFINED, any_time(), any_time());
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed ---
		// still disabled out of reset: re-anchor and a 5 ms wait; process still works
		send_word(OP_SAMPLE, 48'd1000, 48'd1000);
		send_word(OP_PROCESS, 48'd0, 48'd0);
		settle();

		// one tick per ms, one-second frame gap
		configure(1'b1, 10'd1000, 18'd256000, 1'b0);
		send_word(OP_REANCHOR, 48'd0, 48'd0);
		send_word(OP_SAMPLE, 48'd0, 48'd0);         // full wait, 1000 ms
		send_word(OP_SAMPLE, 48'd128, 48'd200);     // under 1 ms: no latency yet
		send_word(OP_SAMPLE, 48'd512, 48'd600);     // latency measured
		send_word(OP_PROCESS, 48'd0, 48'd0);
		send_word(OP_SAMPLE, 48'd300512, 48'd300512); // rate measured, ticks hit the cap
		send_word(OP_PROCESS, 48'd0, 48'd0);        // whole ticks out
		send_word(OP_SAMPLE, 48'd400000, 48'd100);  // recheck behind the anchor
		send_word(OP_SAMPLE, 48'd50, 48'd60);       // sample behind the anchor
		send_word(OP_SAMPLE, '1, '1);               // huge span: latency saturates
		send_word(OP_UNDEFINED, '1, '1);
		send_word(OP_REANCHOR, '1, '0);
		send_word(OP_SAMPLE, '1, '1);               // zero elapsed at the top of time
		settle();

		// speed zero, widest frame gap, single-call
		configure(1'b1, 10'd0, 18'h3FFFF, 1'b1);
		send_word(OP_REANCHOR, 48'd0, 48'd0);
		send_word(OP_PROCESS, 48'd0, 48'd0);
		send_word(OP_SAMPLE, 48'd600000, 48'd600000); // wait clips at 1000 ms
		send_word(OP_PROCESS, 48'd0, 48'd0);        // no ticks at speed zero
		settle();

		// top speed, gap of one LSB, single-call
		configure(1'b1, 10'h3FF, 18'd1, 1'b1);
		send_word(OP_PROCESS, 48'd0, 48'd0);
		send_word(OP_SAMPLE, 48'd700000, 48'd700000);
		send_word(OP_PROCESS, 48'd0, 48'd0);        // one tick, accumulator cleared
		send_word(OP_PROCESS, 48'd0, 48'd0);
		clock_now = 48'd700000;

		// --- random phases, each with its own register setting ---
		for (int p = 0; p < PHASES; p++) begin
			settle();
			case (p)
			0: configure(1'b1, SPEED_RESET, MIN_INTERVAL_RESET, 1'b0);
			1: configure(1'b1, 10'd1000, 18'd256000, 1'b0);
			2: configure(1'b1, 10'd1, 18'd1, 1'b1);
			3: configure(1'b1, 10'd0, 18'h3FFFF, 1'b0);
			4: configure(1'b0, 10'd500, 18'd3000, 1'b0);
			5: configure(1'b1, 10'h3FF, 18'd513, 1'b1);
			default: configure($urandom_range(0, 3) != 0, 10'($urandom_range(0, 1023)),
				18'($urandom_range(0, 262143)), 1'($urandom_range(0, 1)));
			endcase
			// phase 1 is the long stretch with no idling on either side
			idling <= (p != 1);
			repeat (PHASE_WORDS) random_word();
		end

		settle();
		// catch any stray result word after the last expected one
		repeat (100) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#15_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
